>>> rtl/vgmopl_pkg.sv
// Shared types and constants for the VGM OPL command parser.
// No dependencies; every other file refers to it by scoped names.
package vgmopl_pkg;

    // Stream opcodes
    localparam logic [7:0] OP_OPL1     = 8'h5B;
    localparam logic [7:0] OP_OPL2     = 8'h5A;
    localparam logic [7:0] OP_OPL3_P0  = 8'h5E;
    localparam logic [7:0] OP_OPL3_P1  = 8'h5F;
    localparam logic [7:0] OP_OPL2_2ND = 8'hAA;
    localparam logic [7:0] OP_WAIT16   = 8'h61;
    localparam logic [7:0] OP_WAIT735  = 8'h62;
    localparam logic [7:0] OP_WAIT882  = 8'h63;
    localparam logic [7:0] OP_END      = 8'h66;
    localparam logic [3:0] OP_WAITN_HI = 4'h7;

    localparam logic [15:0] WAIT_NTSC      = 16'd735;
    localparam logic [15:0] WAIT_PAL       = 16'd882;
    localparam logic [15:0] MIN_WAIT_RESET = 16'd40;

    // Configuration register indexes
    localparam int          CFG_IDX_W        = 3;
    localparam int          CFG_DATA_W       = 16;
    localparam logic [2:0]  CFG_MODE_OPL1    = 3'd0;
    localparam logic [2:0]  CFG_MODE_OPL3    = 3'd1;
    localparam logic [2:0]  CFG_MODE_DUAL    = 3'd2;
    localparam logic [2:0]  CFG_LOOP_ENABLED = 3'd3;
    localparam logic [2:0]  CFG_MIN_WAIT     = 3'd4;

    // Which mode bit gates a register write
    typedef enum logic [2:0] {
        WCLS_NONE,
        WCLS_OPL1,
        WCLS_OPL2,
        WCLS_OPL3,
        WCLS_DUAL
    } wr_class_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic        write_valid;
        logic        chip_port;
        logic [7:0]  reg_addr;
        logic [7:0]  reg_data;
        logic [15:0] wait_ticks;
        logic        song_end;
        logic        restart;
    } out_item_t;

    // Decoded command passed from front to back
    typedef struct packed {
        wr_class_t   wr_class;
        logic        chip_port;
        logic [7:0]  reg_addr;
        logic [7:0]  reg_data;
        logic [15:0] wait_ticks;
        logic        song_end;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic        mode_opl1;
        logic        mode_opl3;
        logic        mode_dual;
        logic        loop_enabled;
        logic [15:0] min_wait;
    } cfg_t;

endpackage

>>> rtl/vgm_opl_command_parser_top.sv
// Top level of the VGM OPL command parser: configuration registers, front, queue, back.
// Depends on vgmopl_pkg, vgmopl_front, vgmopl_fifo and vgmopl_back.
//
//   channel  direction  handshake                 payload
//   cmd      in         cmd_valid / cmd_ready     data_byte, last_byte
//   res      out        res_valid / res_ready     write_valid .. restart
//   cfg      in         cfg_we                    cfg_index, cfg_wdata
//
// One byte per cycle is taken while cmd_ready is high; a result passes through the queue
// entry and then the back result register on its way to res.
// The queue holds QUEUE_DEPTH decoded commands; cmd_ready drops only when it is full.
// Reset clears parse state, queue pointers and result valid; min_wait resets to 40.
// A stall on res fills the queue before cmd_ready falls.
module vgm_opl_command_parser_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cmd_valid,
    output logic                                  cmd_ready,
    input  vgmopl_pkg::in_item_t                  cmd,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output vgmopl_pkg::out_item_t                 res,
    input  logic                                  cfg_we,
    input  logic [vgmopl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vgmopl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    vgmopl_pkg::cfg_t    cfg_reg;
    vgmopl_pkg::q_stat_t q_stat;
    vgmopl_pkg::cmd_t    push_cmd, pop_cmd;
    logic                push, pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode_opl1    <= 1'b0;
            cfg_reg.mode_opl3    <= 1'b0;
            cfg_reg.mode_dual    <= 1'b0;
            cfg_reg.loop_enabled <= 1'b0;
            cfg_reg.min_wait     <= vgmopl_pkg::MIN_WAIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                vgmopl_pkg::CFG_MODE_OPL1:    cfg_reg.mode_opl1    <= cfg_wdata[0];
                vgmopl_pkg::CFG_MODE_OPL3:    cfg_reg.mode_opl3    <= cfg_wdata[0];
                vgmopl_pkg::CFG_MODE_DUAL:    cfg_reg.mode_dual    <= cfg_wdata[0];
                vgmopl_pkg::CFG_LOOP_ENABLED: cfg_reg.loop_enabled <= cfg_wdata[0];
                vgmopl_pkg::CFG_MIN_WAIT:     cfg_reg.min_wait     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    vgmopl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .q_stat    (q_stat),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    vgmopl_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .stat     (q_stat)
    );

    vgmopl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_stat    (q_stat),
        .q_cmd     (pop_cmd),
        .pop       (pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    a_q_stat_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty together");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !push)
        else $error("push into full queue");

    a_res_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.write_valid || res.wait_ticks != 16'd0 || res.song_end))
        else $error("empty result delivered");

    a_restart_end: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.restart) |-> res.song_end)
        else $error("restart without song end");

    a_idle_write_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.write_valid) |->
            (res.chip_port == 1'b0 && res.reg_addr == 8'd0 && res.reg_data == 8'd0))
        else $error("write fields set on non-write result");

endmodule

>>> rtl/vgmopl_front.sv
// Front end: takes stream bytes, tracks operand phase and emits decoded commands.
// Depends on vgmopl_pkg.
module vgmopl_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  vgmopl_pkg::in_item_t cmd,
    input  vgmopl_pkg::q_stat_t  q_stat,
    output logic                 push,
    output vgmopl_pkg::cmd_t     push_cmd
);

    typedef enum logic [1:0] {
        PH_OPCODE,
        PH_OPERAND1,
        PH_OPERAND2
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] opcode_reg, opcode_next;
    logic [7:0] operand_reg, operand_next;
    logic       accept;
    logic [7:0] b;
    vgmopl_pkg::cmd_t dec;

    assign cmd_ready = !q_stat.full;
    assign accept    = cmd_valid && cmd_ready;
    assign b         = cmd.data_byte;

    always_comb
    begin
        phase_next     = phase_reg;
        opcode_next    = opcode_reg;
        operand_next   = operand_reg;
        dec.wr_class   = vgmopl_pkg::WCLS_NONE;
        dec.chip_port  = 1'b0;
        dec.reg_addr   = operand_reg;
        dec.reg_data   = b;
        dec.wait_ticks = '0;
        dec.song_end   = cmd.last_byte;

        case (phase_reg)
            PH_OPERAND1:
            begin
                operand_next = b;
                phase_next   = PH_OPERAND2;
            end
            PH_OPERAND2:
            begin
                phase_next = PH_OPCODE;
                case (opcode_reg)
                    vgmopl_pkg::OP_WAIT16:   dec.wait_ticks = {b, operand_reg};
                    vgmopl_pkg::OP_OPL1:     dec.wr_class = vgmopl_pkg::WCLS_OPL1;
                    vgmopl_pkg::OP_OPL2:     dec.wr_class = vgmopl_pkg::WCLS_OPL2;
                    vgmopl_pkg::OP_OPL3_P0:  dec.wr_class = vgmopl_pkg::WCLS_OPL3;
                    vgmopl_pkg::OP_OPL3_P1:
                    begin
                        dec.wr_class  = vgmopl_pkg::WCLS_OPL3;
                        dec.chip_port = 1'b1;
                    end
                    vgmopl_pkg::OP_OPL2_2ND:
                    begin
                        dec.wr_class  = vgmopl_pkg::WCLS_DUAL;
                        dec.chip_port = 1'b1;
                    end
                    default: ;
                endcase
            end
            default:
            begin
                phase_next = PH_OPCODE;
                case (b)
                    vgmopl_pkg::OP_OPL1, vgmopl_pkg::OP_OPL2, vgmopl_pkg::OP_OPL3_P0,
                    vgmopl_pkg::OP_OPL3_P1, vgmopl_pkg::OP_OPL2_2ND,
                    vgmopl_pkg::OP_WAIT16:
                    begin
                        opcode_next = b;
                        phase_next  = PH_OPERAND1;
                    end
                    vgmopl_pkg::OP_WAIT735: dec.wait_ticks = vgmopl_pkg::WAIT_NTSC;
                    vgmopl_pkg::OP_WAIT882: dec.wait_ticks = vgmopl_pkg::WAIT_PAL;
                    vgmopl_pkg::OP_END:     dec.song_end   = 1'b1;
                    default:
                    begin
                        if (b[7:4] == vgmopl_pkg::OP_WAITN_HI)
                            dec.wait_ticks = {12'd0, b[3:0]} + 16'd1;
                    end
                endcase
            end
        endcase

        // end of data drops any partial command
        if (dec.song_end)
            phase_next = PH_OPCODE;
    end

    // Only forward bytes that can yield a result
    assign push     = accept && (dec.wr_class != vgmopl_pkg::WCLS_NONE ||
                                 dec.wait_ticks != '0 || dec.song_end);
    assign push_cmd = dec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_OPCODE;
            opcode_reg  <= '0;
            operand_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            opcode_reg  <= opcode_next;
            operand_reg <= operand_next;
        end
    end

endmodule

>>> rtl/vgmopl_fifo.sv
// Short command queue between the front and back ends.
// Depends on vgmopl_pkg for the command and status types.
module vgmopl_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  vgmopl_pkg::cmd_t    push_cmd,
    input  logic                pop,
    output vgmopl_pkg::cmd_t    pop_cmd,
    output vgmopl_pkg::q_stat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    vgmopl_pkg::cmd_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_cmd    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

>>> rtl/vgmopl_back.sv
// Back end: applies chip-mode and minimum-wait filters and holds the result register.
// Depends on vgmopl_pkg.
module vgmopl_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  vgmopl_pkg::cfg_t      cfg,
    input  vgmopl_pkg::q_stat_t   q_stat,
    input  vgmopl_pkg::cmd_t      q_cmd,
    output logic                  pop,
    output logic                  res_valid,
    input  logic                  res_ready,
    output vgmopl_pkg::out_item_t res
);

    logic                  res_valid_reg, res_valid_next;
    vgmopl_pkg::out_item_t res_reg, res_next;
    logic                  wr_ok;
    logic [15:0]           wait_f;
    logic                  has_result;

    always_comb
    begin
        case (q_cmd.wr_class)
            vgmopl_pkg::WCLS_OPL1: wr_ok = cfg.mode_opl1;
            vgmopl_pkg::WCLS_OPL2: wr_ok = !cfg.mode_opl3;
            vgmopl_pkg::WCLS_OPL3: wr_ok = cfg.mode_opl3;
            vgmopl_pkg::WCLS_DUAL: wr_ok = cfg.mode_dual;
            default:               wr_ok = 1'b0;
        endcase
    end

    // drop short waits
    assign wait_f     = (q_cmd.wait_ticks < cfg.min_wait) ? '0 : q_cmd.wait_ticks;
    assign has_result = wr_ok || wait_f != '0 || q_cmd.song_end;
    assign pop        = !q_stat.empty && (!res_valid_reg || res_ready);

    always_comb
    begin
        res_next.write_valid = wr_ok;
        res_next.chip_port   = wr_ok & q_cmd.chip_port;
        res_next.reg_addr    = wr_ok ? q_cmd.reg_addr : '0;
        res_next.reg_data    = wr_ok ? q_cmd.reg_data : '0;
        res_next.wait_ticks  = wait_f;
        res_next.song_end    = q_cmd.song_end;
        res_next.restart     = q_cmd.song_end & cfg.loop_enabled;

        res_valid_next = res_valid_reg && !res_ready;
        if (pop && has_result)
            res_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop && has_result)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

>>> sim/vgm_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the VGM OPL command parser: mirrors parse state and configuration,
// predicts the result of every accepted byte and compares each res transfer against it.
// Depends on vgmopl_pkg.
module vgm_result_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    input  logic                              cmd_ready,
    input  vgmopl_pkg::in_item_t              cmd,
    input  logic                              res_valid,
    input  logic                              res_ready,
    input  vgmopl_pkg::out_item_t             res,
    input  logic                              cfg_we,
    input  logic [vgmopl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vgmopl_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                                fail_count,
    output int                                outstanding
);

    typedef enum logic [1:0] {
        PH_OPCODE,
        PH_OPERAND1,
        PH_OPERAND2
    } parse_phase_t;

    // Mirrored configuration
    logic        cfg_opl1;
    logic        cfg_opl3;
    logic        cfg_dual;
    logic        cfg_loop;
    logic [15:0] cfg_min_wait;

    // Mirrored parse state
    parse_phase_t parse_ph;
    logic [7:0]   held_op;
    logic [7:0]   operand1;

    vgmopl_pkg::out_item_t pending_results[$];
    vgmopl_pkg::out_item_t predicted;
    vgmopl_pkg::out_item_t oldest;
    int                    mismatch_cnt;

    function automatic string fmt_item(input vgmopl_pkg::out_item_t r);
        return $sformatf("wr=%0b port=%0b addr=%02h data=%02h ticks=%0d end=%0b restart=%0b",
                         r.write_valid, r.chip_port, r.reg_addr, r.reg_data,
                         r.wait_ticks, r.song_end, r.restart);
    endfunction

    // Advance the mirrored parser by one byte; return 1 when the byte yields a result.
    function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                      output vgmopl_pkg::out_item_t r);
        logic [15:0] ticks;
        logic        wr;
        logic        port;
        logic        done;
        ticks = '0;
        wr    = 1'b0;
        port  = 1'b0;
        done  = 1'b0;
        r     = '0;
        case (parse_ph)
            PH_OPERAND1:
            begin
                operand1 = b;
                parse_ph = PH_OPERAND2;
            end
            PH_OPERAND2:
            begin
                parse_ph = PH_OPCODE;
                case (held_op)
                    vgmopl_pkg::OP_WAIT16:   ticks = {b, operand1};
                    vgmopl_pkg::OP_OPL1:     wr = cfg_opl1;
                    vgmopl_pkg::OP_OPL2:     wr = !cfg_opl3;
                    vgmopl_pkg::OP_OPL3_P0:  wr = cfg_opl3;
                    vgmopl_pkg::OP_OPL2_2ND:
                    begin
                        wr   = cfg_dual;
                        port = 1'b1;
                    end
                    vgmopl_pkg::OP_OPL3_P1:
                    begin
                        wr   = cfg_opl3;
                        port = 1'b1;
                    end
                    default: ;
                endcase
            end
            default:
            begin
                parse_ph = PH_OPCODE;
                case (b)
                    vgmopl_pkg::OP_OPL1, vgmopl_pkg::OP_OPL2, vgmopl_pkg::OP_OPL3_P0,
                    vgmopl_pkg::OP_OPL3_P1, vgmopl_pkg::OP_OPL2_2ND,
                    vgmopl_pkg::OP_WAIT16:
                    begin
                        held_op  = b;
                        parse_ph = PH_OPERAND1;
                    end
                    vgmopl_pkg::OP_WAIT735: ticks = vgmopl_pkg::WAIT_NTSC;
                    vgmopl_pkg::OP_WAIT882: ticks = vgmopl_pkg::WAIT_PAL;
                    vgmopl_pkg::OP_END:     done = 1'b1;
                    default:
                    begin
                        if (b[7:4] == vgmopl_pkg::OP_WAITN_HI)
                            ticks = {12'd0, b[3:0]} + 16'd1;
                    end
                endcase
            end
        endcase

        // drop short waits
        if (ticks != 16'd0 && ticks < cfg_min_wait)
            ticks = '0;
        if (last)
            done = 1'b1;
        if (done)
            parse_ph = PH_OPCODE;

        r.write_valid = wr;
        r.chip_port   = wr & port;
        r.reg_addr    = wr ? operand1 : 8'd0;
        r.reg_data    = wr ? b : 8'd0;
        r.wait_ticks  = ticks;
        r.song_end    = done;
        r.restart     = done & cfg_loop;
        return wr || ticks != 16'd0 || done;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_opl1     = 1'b0;
            cfg_opl3     = 1'b0;
            cfg_dual     = 1'b0;
            cfg_loop     = 1'b0;
            cfg_min_wait = vgmopl_pkg::MIN_WAIT_RESET;
            parse_ph     = PH_OPCODE;
            held_op      = '0;
            operand1     = '0;
            mismatch_cnt = 0;
            pending_results.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    vgmopl_pkg::CFG_MODE_OPL1:    cfg_opl1 = cfg_wdata[0];
                    vgmopl_pkg::CFG_MODE_OPL3:    cfg_opl3 = cfg_wdata[0];
                    vgmopl_pkg::CFG_MODE_DUAL:    cfg_dual = cfg_wdata[0];
                    vgmopl_pkg::CFG_LOOP_ENABLED: cfg_loop = cfg_wdata[0];
                    vgmopl_pkg::CFG_MIN_WAIT:     cfg_min_wait = cfg_wdata;
                    default: ;
                endcase
            end

            if (cmd_valid && cmd_ready)
            begin
                if (parse_byte(cmd.data_byte, cmd.last_byte, predicted))
                    pending_results.push_back(predicted);
            end

            if (res_valid && res_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    if (mismatch_cnt < 10)
                        $display("%0t: unexpected result transfer: %s", $time, fmt_item(res));
                    mismatch_cnt++;
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    if (res.write_valid !== oldest.write_valid ||
                        res.chip_port   !== oldest.chip_port   ||
                        res.reg_addr    !== oldest.reg_addr    ||
                        res.reg_data    !== oldest.reg_data    ||
                        res.wait_ticks  !== oldest.wait_ticks  ||
                        res.song_end    !== oldest.song_end    ||
                        res.restart     !== oldest.restart)
                    begin
                        if (mismatch_cnt < 10)
                        begin
                            $display("%0t: result mismatch", $time);
                            $display("  expected %s", fmt_item(oldest));
                            $display("  actual   %s", fmt_item(res));
                        end
                        mismatch_cnt++;
                    end
                end
            end

            fail_count  <= mismatch_cnt;
            outstanding <= pending_results.size();
        end
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// Testbench top for the VGM OPL command parser: clock, reset, byte stream stimulus,
// configuration phases and verdict. Depends on vgmopl_pkg and vgm_result_checker.
module tb;

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 155;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 6;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              cmd_valid = 1'b0;
    logic                              cmd_ready;
    vgmopl_pkg::in_item_t              cmd       = '0;
    logic                              res_valid;
    logic                              res_ready = 1'b0;
    vgmopl_pkg::out_item_t             res;
    logic                              cfg_we    = 1'b0;
    logic [vgmopl_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [vgmopl_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    int          fail_count;
    int          outstanding;
    idle_mode_t  idle_mode     = IDLE_NONE;
    bit          hold_off_req  = 1'b0;
    int          hold_left     = 0;
    bit          hold_done     = 1'b0;
    int          cycles        = 0;
    int          sent_items    = 0;
    logic [15:0] cur_min_wait  = vgmopl_pkg::MIN_WAIT_RESET;

    vgm_opl_command_parser_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    vgm_result_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: one long hold-off on request, otherwise stall by idle mode.
    always @(posedge clk)
    begin
        if (hold_off_req && !hold_done)
        begin
            hold_left = HOLD_OFF_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_ready <= 1'b0;
        end
        else
        begin
            case (idle_mode)
                IDLE_RECV: res_ready <= ($urandom_range(0, 99) >= 55);
                IDLE_BOTH: res_ready <= ($urandom_range(0, 99) >= 37);
                default:   res_ready <= 1'b1;
            endcase
        end
    end

    function automatic logic [7:0] write_opcode(input int k);
        case (k)
            0:       return vgmopl_pkg::OP_OPL1;
            1:       return vgmopl_pkg::OP_OPL2;
            2:       return vgmopl_pkg::OP_OPL3_P0;
            3:       return vgmopl_pkg::OP_OPL3_P1;
            default: return vgmopl_pkg::OP_OPL2_2ND;
        endcase
    endfunction

    function automatic logic rand_last();
        return ($urandom_range(0, 99) < 2);
    endfunction

    // Offer one byte and hold it until the transfer.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SEND) ? 55 : (idle_mode == IDLE_BOTH) ? 37 : 0;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= '{data_byte: b, last_byte: last};
        do @(posedge clk); while (!cmd_ready);
    endtask

    task automatic write_cfg(input logic [vgmopl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    // Stop offering and wait until every predicted result has transferred.
    task automatic drain();
        cmd_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_random_command();
        logic [15:0] ticks;
        logic [7:0]  op;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 42)
        begin
            send_byte(write_opcode($urandom_range(0, 4)), 1'b0);
            send_byte(8'($urandom_range(0, 255)), 1'b0);
            send_byte(8'($urandom_range(0, 255)), rand_last());
            sent_items += 3;
        end
        else if (pick < 57)
        begin
            case ($urandom_range(0, 3))
                0:       ticks = 16'($urandom_range(0, 65535));
                1:       ticks = 16'($urandom_range(0, 255));
                default: ticks = cur_min_wait + 16'($urandom_range(0, 2)) - 16'd1;
            endcase
            send_byte(vgmopl_pkg::OP_WAIT16, 1'b0);
            send_byte(ticks[7:0], 1'b0);
            send_byte(ticks[15:8], rand_last());
            sent_items += 3;
        end
        else if (pick < 65)
        begin
            send_byte($urandom_range(0, 1) ? vgmopl_pkg::OP_WAIT735 : vgmopl_pkg::OP_WAIT882,
                      rand_last());
            sent_items += 1;
        end
        else if (pick < 78)
        begin
            send_byte({vgmopl_pkg::OP_WAITN_HI, 4'($urandom_range(0, 15))}, rand_last());
            sent_items += 1;
        end
        else if (pick < 83)
        begin
            send_byte(vgmopl_pkg::OP_END, rand_last());
            sent_items += 1;
        end
        else if (pick < 90)
        begin
            // cut a command short with the last byte
            op = $urandom_range(0, 5) == 5 ? vgmopl_pkg::OP_WAIT16
                                           : write_opcode($urandom_range(0, 4));
            if ($urandom_range(0, 1))
            begin
                send_byte(op, 1'b1);
                sent_items += 1;
            end
            else
            begin
                send_byte(op, 1'b0);
                send_byte(8'($urandom_range(0, 255)), 1'b1);
                sent_items += 2;
            end
        end
        else
        begin
            send_byte(8'($urandom_range(0, 255)), rand_last());
            sent_items += 1;
        end
    endtask

    initial
    begin
        vgmopl_pkg::cfg_t setting;
        int               ph;
        int               target;
        bit               paused;
        paused = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed stream under reset settings: OPL2 only, min wait 40, no loop.
        send_byte(vgmopl_pkg::OP_OPL2, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(vgmopl_pkg::OP_OPL1, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(vgmopl_pkg::OP_OPL3_P0, 1'b0);
        send_byte(8'h56, 1'b0);
        send_byte(8'h78, 1'b0);
        send_byte(vgmopl_pkg::OP_OPL3_P1, 1'b0);
        send_byte(8'h9A, 1'b0);
        send_byte(8'hBC, 1'b0);
        send_byte(vgmopl_pkg::OP_OPL2_2ND, 1'b0);
        send_byte(8'hDE, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(vgmopl_pkg::OP_WAIT16, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(vgmopl_pkg::OP_WAIT16, 1'b0);
        send_byte(8'd39, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(vgmopl_pkg::OP_WAIT735, 1'b0);
        send_byte(vgmopl_pkg::OP_WAIT882, 1'b0);
        send_byte(8'h70, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(vgmopl_pkg::OP_END, 1'b0);
        send_byte(vgmopl_pkg::OP_OPL2, 1'b0);
        send_byte(8'h10, 1'b1);
        send_byte(vgmopl_pkg::OP_WAIT735, 1'b1);
        drain();

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:       setting = '{1'b1, 1'b0, 1'b1, 1'b1, 16'd0};
                1:       setting = '{1'b0, 1'b1, 1'b0, 1'b0, 16'hFFFF};
                2:       setting = '{1'b1, 1'b1, 1'b1, 1'b1, 16'd1};
                default:
                begin
                    setting.mode_opl1    = 1'($urandom_range(0, 1));
                    setting.mode_opl3    = 1'($urandom_range(0, 1));
                    setting.mode_dual    = 1'($urandom_range(0, 1));
                    setting.loop_enabled = 1'($urandom_range(0, 1));
                    case ($urandom_range(0, 3))
                        0:       setting.min_wait = 16'($urandom_range(1, 20));
                        1:       setting.min_wait = vgmopl_pkg::WAIT_NTSC;
                        2:       setting.min_wait = vgmopl_pkg::WAIT_PAL + 16'd1;
                        default: setting.min_wait = 16'($urandom_range(0, 65535));
                    endcase
                end
            endcase
            write_cfg(vgmopl_pkg::CFG_MODE_OPL1, {15'd0, setting.mode_opl1});
            write_cfg(vgmopl_pkg::CFG_MODE_OPL3, {15'd0, setting.mode_opl3});
            write_cfg(vgmopl_pkg::CFG_MODE_DUAL, {15'd0, setting.mode_dual});
            write_cfg(vgmopl_pkg::CFG_LOOP_ENABLED, {15'd0, setting.loop_enabled});
            write_cfg(vgmopl_pkg::CFG_MIN_WAIT, setting.min_wait);
            cfg_we <= 1'b0;
            cur_min_wait = setting.min_wait;
            idle_mode <= idle_mode_t'(ph % 4);
            if (ph == 4)
                hold_off_req <= 1'b1;

            target = sent_items + ITEMS_PER_PHASE;
            while (sent_items < target)
            begin
                send_random_command();
                // pause the stream once until the block has drained
                if (ph == 5 && !paused && sent_items >= target - ITEMS_PER_PHASE / 2)
                begin
                    drain();
                    paused = 1'b1;
                end
            end
            send_byte(vgmopl_pkg::OP_END, 1'b1);
            drain();
        end

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
